FILE: rtl/frf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frf_pkg
// Constants, register map and reset values of the flashing ratchet field.
// ----------------------------------------------------------------------------
package frf_pkg;

  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned WRAP_STEPS  = 32;
  localparam int unsigned QUOT_STEPS  = 33;
  localparam int unsigned ADDR_W      = 5;

  typedef enum logic [2:0] {
    REG_RISE_LENGTH     = 3'd0,
    REG_FALL_LENGTH     = 3'd1,
    REG_FIELD_HIGH      = 3'd2,
    REG_FIELD_LOW       = 3'd3,
    REG_FIELD_WHEN_DARK = 3'd4,
    REG_LIGHT_PERIOD    = 3'd5,
    REG_LIGHT_DURATION  = 3'd6,
    REG_SLOPE_WHEN_DARK = 3'd7
  } reg_idx_e;

  localparam logic [30:0] RST_RISE   = 31'(1) << FRAC_BITS;
  localparam logic [30:0] RST_FALL   = 31'(1) << FRAC_BITS;
  localparam logic [31:0] RST_HIGH   = 32'(1) << FRAC_BITS;
  localparam logic [31:0] RST_LOW    = 32'd0;
  localparam logic [31:0] RST_DKF    = 32'd0;
  localparam logic [31:0] RST_PERIOD = 32'(1) << FRAC_BITS;
  localparam logic [31:0] RST_DUR    = 32'(1) << (FRAC_BITS - 1);
  localparam logic [31:0] RST_DKS    = 32'(10) << FRAC_BITS;

endpackage

FILE: rtl/flashing_ratchet_field_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flashing_ratchet_field_top
// Pipelined flashing ratchet potential: field value and slope per particle.
// ----------------------------------------------------------------------------
// Usage: a particle beat (position_i, sim_time_i) enters on in_valid_i and
// in_ready_o; the result beat (pot_value_o, field_slope_o, lit_o, rising_o)
// leaves on out_valid_o and out_ready_i. The APB port holds the eight
// configuration registers at byte addresses 0 to 28; the user must write them
// only while no beat is in flight, as the block itself does not enforce it.
// The result beat passes 70 register stages, and one beat is accepted in
// every cycle in which the receiver takes the result or none is waiting. The
// stages are an input stage, two bit-serial remainder pipelines of 32 stages
// side by side (light phase and position wrap), a wrap stage, a multiply
// stage, two quotient pipelines side by side (field value and slope), each of
// an input stage and 33 steps, and the output register.
// Reset clears every valid bit and loads the default registers. When the
// receiver stalls with a result waiting, the whole pipeline holds and
// in_ready_o falls, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module flashing_ratchet_field_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frf_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            position_i,
  input  logic [31:0]                   sim_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            pot_value_o,
  output logic signed [31:0]            field_slope_o,
  output logic                          lit_o,
  output logic                          rising_o
);

  localparam int unsigned NA = frf_pkg::WRAP_STEPS;
  localparam int unsigned NC = frf_pkg::QUOT_STEPS;

  logic [30:0] rise_q, fall_q;
  logic [31:0] high_q, low_q, dkf_q, lper_q, ldur_q, dks_q;
  logic [30:0] rise_e_q, fall_e_q;
  logic [31:0] per_q;
  logic [32:0] adiff_q;
  logic        dneg_q;
  logic        wr_en;
  logic [32:0] diff;
  logic [30:0] rise_eff, fall_eff;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q <= frf_pkg::RST_RISE;
      fall_q <= frf_pkg::RST_FALL;
      high_q <= frf_pkg::RST_HIGH;
      low_q  <= frf_pkg::RST_LOW;
      dkf_q  <= frf_pkg::RST_DKF;
      lper_q <= frf_pkg::RST_PERIOD;
      ldur_q <= frf_pkg::RST_DUR;
      dks_q  <= frf_pkg::RST_DKS;
    end else if (wr_en) begin
      unique case (frf_pkg::reg_idx_e'(paddr[4:2]))
        frf_pkg::REG_RISE_LENGTH:     rise_q <= pwdata[30:0];
        frf_pkg::REG_FALL_LENGTH:     fall_q <= pwdata[30:0];
        frf_pkg::REG_FIELD_HIGH:      high_q <= pwdata;
        frf_pkg::REG_FIELD_LOW:       low_q  <= pwdata;
        frf_pkg::REG_FIELD_WHEN_DARK: dkf_q  <= pwdata;
        frf_pkg::REG_LIGHT_PERIOD:    lper_q <= pwdata;
        frf_pkg::REG_LIGHT_DURATION:  ldur_q <= pwdata;
        frf_pkg::REG_SLOPE_WHEN_DARK: dks_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (frf_pkg::reg_idx_e'(paddr[4:2]))
      frf_pkg::REG_RISE_LENGTH:     prdata = {1'b0, rise_q};
      frf_pkg::REG_FALL_LENGTH:     prdata = {1'b0, fall_q};
      frf_pkg::REG_FIELD_HIGH:      prdata = high_q;
      frf_pkg::REG_FIELD_LOW:       prdata = low_q;
      frf_pkg::REG_FIELD_WHEN_DARK: prdata = dkf_q;
      frf_pkg::REG_LIGHT_PERIOD:    prdata = lper_q;
      frf_pkg::REG_LIGHT_DURATION:  prdata = ldur_q;
      frf_pkg::REG_SLOPE_WHEN_DARK: prdata = dks_q;
      default:                      prdata = 32'd0;
    endcase
  end

  // Derived settings are registered copies, taken in the cycle after the registers change.
  assign diff     = {high_q[31], high_q} - {low_q[31], low_q};
  assign rise_eff = (rise_q == 31'd0) ? 31'd1 : rise_q;
  assign fall_eff = (fall_q == 31'd0) ? 31'd1 : fall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_e_q <= frf_pkg::RST_RISE;
      fall_e_q <= frf_pkg::RST_FALL;
      per_q    <= 32'(frf_pkg::RST_RISE) + 32'(frf_pkg::RST_FALL);
      adiff_q  <= 33'(frf_pkg::RST_HIGH);
      dneg_q   <= 1'b0;
    end else begin
      rise_e_q <= rise_eff;
      fall_e_q <= fall_eff;
      per_q    <= {1'b0, rise_eff} + {1'b0, fall_eff};
      adiff_q  <= diff[32] ? (33'd0 - diff) : diff;
      dneg_q   <= diff[32];
    end
  end

  function automatic logic [63:0] rem_step(input logic [31:0] r, input logic [31:0] dv,
                                            input logic [31:0] d);
    logic [33:0] trial;
    logic [31:0] rn;
    trial = {1'b0, r, dv[31]} - {2'b00, d};
    rn    = trial[33] ? {r[30:0], dv[31]} : trial[31:0];
    return {rn, dv[30:0], 1'b0};
  endfunction

  function automatic logic [63:0] quo_step(input logic [30:0] r, input logic [32:0] qv,
                                            input logic [30:0] d);
    logic [32:0] trial;
    logic [30:0] rn;
    trial = {1'b0, r, qv[32]} - {2'b00, d};
    rn    = trial[32] ? {r[29:0], qv[32]} : trial[30:0];
    return {rn, qv[31:0], ~trial[32]};
  endfunction

  logic        en;
  logic        out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Remainder pipelines: light phase and position wrap.
  logic [31:0] ra_q [0:NA];
  logic [31:0] da_q [0:NA];
  logic [31:0] rb_q [0:NA];
  logic [31:0] db_q [0:NA];
  logic        ng_q [0:NA];
  logic        va_q [0:NA];

  // Wrap stage, multiply stage.
  logic        vw_q, w_lit_q, w_ris_q;
  logic [30:0] w_xr_q;
  logic        vm_q, m_lit_q, m_ris_q;
  logic [48:0] m_lo_q;
  logic [47:0] m_hi_q;

  // Quotient pipelines: value and slope.
  logic [30:0] rv_q [0:NC];
  logic [32:0] qv_q [0:NC];
  logic [30:0] rs_q [0:NC];
  logic [32:0] qs_q [0:NC];
  logic        ri_q [0:NC];
  logic        li_q [0:NC];
  logic        ov_q [0:NC];
  logic        vc_q [0:NC];

  logic [31:0] x, rb_end, x_sub;
  logic        w_ris_d;
  logic [64:0] num_v, num_s;
  logic [30:0] d_n;

  assign rb_end  = rb_q[NA];
  assign x       = (ng_q[NA] && rb_end != 32'd0) ? per_q - rb_end : rb_end;
  assign w_ris_d = x < {1'b0, rise_e_q};
  assign x_sub   = x - {1'b0, rise_e_q};

  assign d_n   = m_ris_q ? rise_e_q : fall_e_q;
  assign num_v = {16'd0, m_lo_q} + ({17'd0, m_hi_q} << 16);
  assign num_s = {32'd0, adiff_q} << frf_pkg::FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NA; k++) va_q[k] <= 1'b0;
      for (int k = 0; k <= NC; k++) vc_q[k] <= 1'b0;
      vw_q        <= 1'b0;
      vm_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q[0] <= in_valid_i;
      for (int k = 1; k <= NA; k++) va_q[k] <= va_q[k-1];
      vw_q    <= va_q[NA];
      vm_q    <= vw_q;
      vc_q[0] <= vm_q;
      for (int k = 1; k <= NC; k++) vc_q[k] <= vc_q[k-1];
      out_valid_q <= vc_q[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q[0] <= 32'd0;
      da_q[0] <= sim_time_i;
      rb_q[0] <= 32'd0;
      db_q[0] <= position_i[31] ? (32'd0 - position_i) : position_i;
      ng_q[0] <= position_i[31];
      for (int k = 1; k <= NA; k++) begin
        {ra_q[k], da_q[k]} <= rem_step(ra_q[k-1], da_q[k-1], lper_q);
        {rb_q[k], db_q[k]} <= rem_step(rb_q[k-1], db_q[k-1], per_q);
        ng_q[k] <= ng_q[k-1];
      end

      w_lit_q <= ra_q[NA] < ldur_q;
      w_ris_q <= w_ris_d;
      w_xr_q  <= w_ris_d ? x[30:0] : x_sub[30:0];

      m_lo_q  <= 49'(adiff_q) * 49'(w_xr_q[15:0]);
      m_hi_q  <= 48'(adiff_q) * 48'(w_xr_q[30:16]);
      m_lit_q <= w_lit_q;
      m_ris_q <= w_ris_q;

      rv_q[0] <= num_v[63:33];
      qv_q[0] <= num_v[32:0];
      rs_q[0] <= num_s[63:33];
      qs_q[0] <= num_s[32:0];
      ov_q[0] <= num_s[64:33] >= {1'b0, d_n};
      ri_q[0] <= m_ris_q;
      li_q[0] <= m_lit_q;
      for (int k = 1; k <= NC; k++) begin
        {rv_q[k], qv_q[k]} <= quo_step(rv_q[k-1], qv_q[k-1],
                                       ri_q[k-1] ? rise_e_q : fall_e_q);
        {rs_q[k], qs_q[k]} <= quo_step(rs_q[k-1], qs_q[k-1],
                                       ri_q[k-1] ? rise_e_q : fall_e_q);
        ri_q[k] <= ri_q[k-1];
        li_q[k] <= li_q[k-1];
        ov_q[k] <= ov_q[k-1];
      end
    end
  end

  logic [33:0] qsig, val34;
  logic [32:0] qv_end, qs_end;
  logic        sneg, ssat;
  logic [31:0] slope_d, value_d;

  assign qv_end = qv_q[NC];
  assign qs_end = qs_q[NC];
  assign qsig   = dneg_q ? (34'd0 - {1'b0, qv_end}) : {1'b0, qv_end};
  assign val34  = ri_q[NC] ? ({{2{low_q[31]}}, low_q} + qsig)
                           : ({{2{high_q[31]}}, high_q} - qsig);
  assign sneg   = dneg_q ^ ~ri_q[NC];
  assign ssat   = ov_q[NC] || (sneg ? (qs_end > 33'h0_8000_0000)
                                    : (qs_end > 33'h0_7FFF_FFFF));

  always_comb begin
    if (ssat) begin
      slope_d = sneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      slope_d = sneg ? (32'd0 - qs_end[31:0]) : qs_end[31:0];
    end
    value_d = val34[31:0];
  end

  logic [31:0] fv_q, fs_q;
  logic        lit_q, ris_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lit_q <= li_q[NC];
      ris_q <= li_q[NC] & ri_q[NC];
      fv_q  <= li_q[NC] ? value_d : dkf_q;
      fs_q  <= li_q[NC] ? slope_d : dks_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pot_value_o   = fv_q;
  assign field_slope_o = fs_q;
  assign lit_o         = lit_q;
  assign rising_o      = ris_q;

  a_dark_not_rising: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lit_o |-> !rising_o)
    else $error("rising reported while the light is off");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while the result beat is stalled");

  a_value_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lit_o && ($signed(high_q) >= $signed(low_q)) |->
      ($signed(pot_value_o) >= $signed(low_q)) &&
      ($signed(pot_value_o) <= $signed(high_q)))
    else $error("field value outside the ramp range");

  a_rising_slope_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rising_o && ($signed(high_q) >= $signed(low_q)) |->
      !field_slope_o[31])
    else $error("rising slope has the wrong sign");

endmodule
